// ===== hw/rtl/ilc_pkg.sv =====
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types and constants for the indexed list with compaction.
// ----------------------------------------------------------------------------
package ilc_pkg;

    // Fixed field widths of the request and result items
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned INDEX_W     = 8;
    localparam int unsigned COUNT_OUT_W = 9;

    // Operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    // Status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // Request item
    typedef struct packed {
        logic [1:0]         operation;
        logic [INDEX_W-1:0] index;
        logic [DATA_W-1:0]  data_in;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [DATA_W-1:0]      data_out;
        logic                   status;
        logic [COUNT_OUT_W-1:0] count;
    } t_out_item;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic go;      // an item is accepted this cycle
        logic append;  // write the new element at the address
        logic remove;  // cells at or above the address take their neighbour's value
        logic read;    // the cell at the address puts its element on the read tree
    } t_cell_cmd;

endpackage

// ===== hw/rtl/ilc_cell.sv =====
// ----------------------------------------------------------------------------
// ilc_cell
// One storage cell of the list: holds one element, shifts from its upper
// neighbour on a remove and offers its element to the read tree.
// ----------------------------------------------------------------------------
module ilc_cell #(
    parameter int unsigned ELEM_WIDTH = 32,
    parameter int unsigned IDX_W      = 8,
    parameter int unsigned CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  ilc_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_W-1:0]      i_addr,
    input  logic [ELEM_WIDTH-1:0] i_wr_data,
    input  logic [ELEM_WIDTH-1:0] i_upper_data,
    output logic [ELEM_WIDTH-1:0] o_data,
    output logic [ELEM_WIDTH-1:0] o_tap
);
    import ilc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] r_tap;
    logic                  w_hit;
    logic                  w_at_or_above;

    assign w_hit         = (i_addr == MY_IDX);
    assign w_at_or_above = (MY_IDX >= i_addr);

    // Write on append, take the upper neighbour on remove, else hold
    always_ff @(posedge i_clk) begin
        if (i_cmd.go && i_cmd.append && w_hit) begin
            r_data <= i_wr_data;
        end else if (i_cmd.go && i_cmd.remove && w_at_or_above) begin
            r_data <= i_upper_data;
        end
    end

    // Capture the old element for the read tree, zero when not selected
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_tap <= (i_cmd.read && w_hit) ? r_data : '0;
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

// ===== hw/rtl/ilc_or_tree.sv =====
// ----------------------------------------------------------------------------
// ilc_or_tree
// Registered binary OR tree that gathers the one selected cell element.
// One register level per tree level.
// ----------------------------------------------------------------------------
module ilc_or_tree #(
    parameter int unsigned ELEM_WIDTH = 32,
    parameter int unsigned LEAVES     = 256
) (
    input  logic                  i_clk,
    input  logic [ELEM_WIDTH-1:0] i_leaf [LEAVES],
    output logic [ELEM_WIDTH-1:0] o_root
);
    import ilc_pkg::*;

    // Heap order: node n has children 2n and 2n+1, leaves follow the nodes
    logic [ELEM_WIDTH-1:0] r_node [1:LEAVES-1];

    for (genvar n = 1; n < LEAVES; n++) begin : g_node
        logic [ELEM_WIDTH-1:0] w_left;
        logic [ELEM_WIDTH-1:0] w_right;

        if (2 * n >= LEAVES) begin : g_leaf_kids
            assign w_left  = i_leaf[2 * n - LEAVES];
            assign w_right = i_leaf[2 * n + 1 - LEAVES];
        end else begin : g_node_kids
            assign w_left  = r_node[2 * n];
            assign w_right = r_node[2 * n + 1];
        end

        // Merge the two children
        always_ff @(posedge i_clk) begin
            r_node[n] <= w_left | w_right;
        end
    end

    assign o_root = r_node[1];

endmodule

// ===== hw/rtl/indexed_list_with_compaction.sv =====
// ----------------------------------------------------------------------------
// indexed_list_with_compaction
// Bounded ordered list with append, pop, read and remove-with-compaction.
// ----------------------------------------------------------------------------
// The list is a chain of DEPTH cells, one element each. A request is taken
// when the block is idle; its write, or the one-place shift of every later
// cell on a remove, happens in the cycle it is accepted. The returned element
// is gathered through a registered OR tree of $clog2(DEPTH) levels, and the
// result item is offered once the element has passed every level of the
// tree. The next item is taken in the cycle after the result leaves: the
// block takes no new request while the last one is still in flight.
// Status and count in the result describe the list after the operation; an
// erroring request leaves the list unchanged and returns zero data.
module indexed_list_with_compaction #(
    parameter int unsigned DEPTH      = 256,
    parameter int unsigned ELEM_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ilc_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output ilc_pkg::t_out_item o_item
);
    import ilc_pkg::*;

    localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned LEAVES  = 2 ** IDX_W;
    localparam int unsigned LEVELS  = IDX_W;
    localparam int unsigned WAIT_W  = $clog2(LEVELS + 1);
    localparam int unsigned XW      = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [WAIT_W-1:0] WAIT_INIT  = WAIT_W'(LEVELS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WAIT = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic              r_status, n_status;

    logic              w_accept;
    logic              w_err;
    logic [XW-1:0]     w_count_x;
    logic [XW-1:0]     w_index_x;
    logic [IDX_W-1:0]  w_addr;
    t_cell_cmd         w_cmd;

    logic [ELEM_WIDTH-1:0] w_wr_data;
    logic [ELEM_WIDTH-1:0] w_data [DEPTH];
    logic [ELEM_WIDTH-1:0] w_tap  [DEPTH];
    logic [ELEM_WIDTH-1:0] w_leaf [LEAVES];
    logic [ELEM_WIDTH-1:0] w_root;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_count_x = XW'(r_count);
    assign w_index_x = XW'(i_item.index);
    assign w_wr_data = ELEM_WIDTH'(i_item.data_in);

    // Decode the request: error check, new count and cell command
    always_comb begin
        w_err   = 1'b0;
        n_count = r_count;
        w_addr  = IDX_W'(i_item.index);
        w_cmd   = '0;
        w_cmd.go = w_accept;
        unique case (i_item.operation)
            OP_APPEND: begin
                w_err  = (r_count == FULL_COUNT);
                w_addr = IDX_W'(r_count);
                w_cmd.append = !w_err;
                if (!w_err) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_POP: begin
                w_err  = (r_count == '0);
                w_addr = IDX_W'(r_count - CNT_W'(1));
                w_cmd.read = !w_err;
                if (!w_err) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                w_err = (w_index_x >= w_count_x);
                w_cmd.read = !w_err;
            end
            OP_REMOVE: begin
                w_err = (w_index_x >= w_count_x);
                w_cmd.read   = !w_err;
                w_cmd.remove = !w_err;
                if (!w_err) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_err = 1'b1;
            end
        endcase
    end

    // Sequence one item: accept, wait for the read tree, offer the result
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_WAIT;
                    n_wait   = WAIT_INIT;
                    n_status = w_err ? ST_ERROR : ST_OK;
                end
            end
            S_WAIT: begin
                n_wait = r_wait - WAIT_W'(1);
                if (r_wait == WAIT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_wait   <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_status <= n_status;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Chain of cells; the top cell shifts in its own value
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_upper;

        if (i + 1 < DEPTH) begin : g_mid
            assign w_upper = w_data[i + 1];
        end else begin : g_top
            assign w_upper = w_data[i];
        end

        ilc_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_addr       (w_addr),
            .i_wr_data    (w_wr_data),
            .i_upper_data (w_upper),
            .o_data       (w_data[i]),
            .o_tap        (w_tap[i])
        );
    end

    // Pad the tree leaves past the last cell with zero
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < DEPTH) begin : g_used
            assign w_leaf[i] = w_tap[i];
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    ilc_or_tree #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .LEAVES     (LEAVES)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // Result item
    assign o_valid         = (r_state == S_OUT);
    assign o_item.data_out = DATA_W'(w_root);
    assign o_item.status   = r_status;
    assign o_item.count    = COUNT_OUT_W'(w_count_x);

endmodule
